@@ rtl/core/vrst_pkg.sv @@
`timescale 1ns / 1ps

package vrst_pkg;

	// Field widths
	localparam int BIDX_W   = 9;
	localparam int BITS_W   = 8;
	localparam int ROW_W    = 16;
	localparam int COL_W    = 12;
	localparam int END_W    = 17;
	localparam int SEG_W    = 16;
	localparam int RB_W     = 10;
	localparam int LAG_W    = 6;
	localparam int POS_W    = 3;

	// Column store
	localparam int MAX_COLUMNS = 4096;
	localparam int ADDR_W      = $clog2(MAX_COLUMNS);

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_BYTES     = 2'd0,
		REG_SEGMENT_LIMIT = 2'd1,
		REG_END_LAG       = 2'd2
	} cfg_reg_t;

	localparam logic [RB_W-1:0]  ROW_BYTES_RST     = RB_W'(512);
	localparam logic [SEG_W-1:0] SEGMENT_LIMIT_RST = '1;
	localparam logic [LAG_W-1:0] END_LAG_RST       = '0;

	localparam logic [ROW_W-1:0] START_OFFSET = ROW_W'(16);

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

	// One classified byte, queued between front and back
	typedef struct packed {
		logic [BIDX_W-1:0] bidx;
		logic [BITS_W-1:0] born;
		logic [BITS_W-1:0] died;
		logic [ROW_W-1:0]  start_row;
		logic [END_W-1:0]  end_row;
	} work_t;

	typedef struct packed {
		logic [ROW_W-1:0] start_row;
		logic [SEG_W-1:0] seg;
	} mem_entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BIRTH,
		ST_DREAD,
		ST_DEMIT
	} back_state_t;

	// Position of the leftmost set bit, counted from the MSB
	function automatic logic [POS_W-1:0] first_set(input logic [BITS_W-1:0] mask);
		logic [POS_W-1:0] pos;
		pos = '0;
		for (int k = 0; k < BITS_W; k++) begin
			if (mask[k]) begin
				pos = POS_W'(BITS_W - 1 - k);
			end
		end
		return pos;
	endfunction

	function automatic logic [BITS_W-1:0] clear_pos(input logic [BITS_W-1:0] mask,
			input logic [POS_W-1:0] pos);
		logic [BITS_W-1:0] bit_sel;
		bit_sel = {1'b1, {(BITS_W-1){1'b0}}} >> pos;
		return mask & ~bit_sel;
	endfunction

endpackage

@@ rtl/core/vrst_if.sv @@
`timescale 1ns / 1ps

interface vrst_in_if;
	logic                         valid;
	logic                         ready;
	logic [vrst_pkg::BIDX_W-1:0]  byte_index;
	logic [vrst_pkg::BITS_W-1:0]  above_bits;
	logic [vrst_pkg::BITS_W-1:0]  filtered_bits;
	logic [vrst_pkg::BITS_W-1:0]  next_bits;
	logic [vrst_pkg::ROW_W-1:0]   row;

	modport source (output valid, byte_index, above_bits, filtered_bits, next_bits, row,
		input ready);
	modport sink (input valid, byte_index, above_bits, filtered_bits, next_bits, row,
		output ready);
endinterface

interface vrst_out_if;
	logic                               valid;
	logic                               ready;
	logic [vrst_pkg::COL_W-1:0]         column;
	logic [vrst_pkg::ROW_W-1:0]         start_row;
	logic signed [vrst_pkg::END_W-1:0]  end_row;
	logic [vrst_pkg::SEG_W-1:0]         segment_number;
	logic                               overflow;
	logic                               last;

	modport source (output valid, column, start_row, end_row, segment_number, overflow, last,
		input ready);
	modport sink (input valid, column, start_row, end_row, segment_number, overflow, last,
		output ready);
endinterface

@@ rtl/core/vrst_fifo.sv @@
`timescale 1ns / 1ps

module vrst_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  vrst_pkg::work_t push_data,
	output logic            full,
	input  logic            pop,
	output vrst_pkg::work_t pop_data,
	output logic            empty
);
	import vrst_pkg::*;

	work_t                 entries_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wptr_q;
	logic [FIFO_PTR_W-1:0] rptr_q;
	logic [FIFO_PTR_W:0]   count_q;

	assign full     = (count_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign empty    = (count_q == '0);
	assign pop_data = entries_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/vrst_front.sv @@
`timescale 1ns / 1ps

module vrst_front (
	vrst_in_if.sink                   items,
	input  logic [vrst_pkg::RB_W-1:0]  row_bytes,
	input  logic [vrst_pkg::LAG_W-1:0] end_lag,
	input  logic                       full,
	output logic                       push,
	output vrst_pkg::work_t            push_data
);
	import vrst_pkg::*;

	logic skip;
	logic [BITS_W-1:0] born;
	logic [BITS_W-1:0] died;

	// last byte of the row and anything past it do nothing
	assign skip = ({1'b0, items.byte_index} + RB_W'(1)) >= row_bytes;
	assign born = items.above_bits & ~items.filtered_bits;
	assign died = ~items.filtered_bits & items.next_bits;

	assign items.ready = !full;
	// bytes with no transition produce no result and are dropped here
	assign push = items.valid && !full && !skip && ((born | died) != '0);

	always_comb begin
		push_data.bidx      = items.byte_index;
		push_data.born      = born;
		push_data.died      = died;
		push_data.start_row = items.row - START_OFFSET;
		push_data.end_row   = {1'b0, items.row} - END_W'(1) - END_W'(end_lag);
	end

endmodule

@@ rtl/core/vrst_back.sv @@
`timescale 1ns / 1ps

module vrst_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [vrst_pkg::SEG_W-1:0] segment_limit,
	input  logic                       empty,
	input  vrst_pkg::work_t            head,
	output logic                       pop,
	vrst_out_if.source                 results
);
	import vrst_pkg::*;

	back_state_t state_q, state_d;

	logic [BIDX_W-1:0] bidx_q;
	logic [BITS_W-1:0] born_q;
	logic [BITS_W-1:0] died_q;
	logic [ROW_W-1:0]  start_q;
	logic [END_W-1:0]  end_q;
	logic [SEG_W-1:0]  seg_cnt_q;
	logic              ovf_q;
	logic [POS_W-1:0]  rd_pos_q;
	logic              last_q;

	mem_entry_t mem [MAX_COLUMNS];
	mem_entry_t rd_data_q;

	logic              out_valid_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_start_q;
	logic [END_W-1:0]  out_end_q;
	logic [SEG_W-1:0]  out_seg_q;
	logic              out_ovf_q;
	logic              out_last_q;

	logic              out_free;
	logic              limit_hit;
	logic [POS_W-1:0]  birth_pos;
	logic [POS_W-1:0]  death_pos;
	logic [BITS_W-1:0] born_next;
	logic [BITS_W-1:0] died_next;

	logic load_item;
	logic mem_we;
	logic rd_en;
	logic load_res;
	logic load_err;

	assign out_free  = !out_valid_q || results.ready;
	assign limit_hit = seg_cnt_q >= segment_limit;
	assign birth_pos = first_set(born_q);
	assign death_pos = first_set(died_q);
	assign born_next = clear_pos(born_q, birth_pos);
	assign died_next = clear_pos(died_q, death_pos);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!empty && !ovf_q) begin
					state_d = (head.born != '0) ? ST_BIRTH : ST_DREAD;
				end
			end
			ST_BIRTH: begin
				if (limit_hit) begin
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else if (born_next == '0) begin
					state_d = (died_q != '0) ? ST_DREAD : ST_IDLE;
				end
			end
			ST_DREAD: begin
				state_d = ST_DEMIT;
			end
			ST_DEMIT: begin
				if (out_free) begin
					state_d = last_q ? ST_IDLE : ST_DREAD;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control outputs
	always_comb begin
		pop       = 1'b0;
		load_item = 1'b0;
		mem_we    = 1'b0;
		rd_en     = 1'b0;
		load_res  = 1'b0;
		load_err  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				pop       = !empty;
				load_item = !empty && !ovf_q;
			end
			ST_BIRTH: begin
				load_err = limit_hit && out_free;
				mem_we   = !limit_hit;
			end
			ST_DREAD: begin
				rd_en = 1'b1;
			end
			ST_DEMIT: begin
				load_res = out_free;
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	// column store: start row and segment number per column
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[ADDR_W'({bidx_q, birth_pos})] <= '{start_row: start_q, seg: seg_cnt_q};
		end
		if (rd_en) begin
			rd_data_q <= mem[ADDR_W'({bidx_q, death_pos})];
		end
	end

	// item payload
	always_ff @(posedge clk) begin
		if (load_item) begin
			bidx_q  <= head.bidx;
			start_q <= head.start_row;
			end_q   <= head.end_row;
		end
		if (rd_en) begin
			rd_pos_q <= death_pos;
			last_q   <= (died_next == '0);
		end
		if (load_res) begin
			out_col_q   <= {bidx_q, rd_pos_q};
			out_start_q <= rd_data_q.start_row;
			out_end_q   <= end_q;
			out_seg_q   <= rd_data_q.seg;
			out_ovf_q   <= 1'b0;
			out_last_q  <= last_q;
		end else if (load_err) begin
			out_col_q   <= '0;
			out_start_q <= '0;
			out_end_q   <= '0;
			out_seg_q   <= '0;
			out_ovf_q   <= 1'b1;
			out_last_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			born_q      <= '0;
			died_q      <= '0;
			seg_cnt_q   <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_item) begin
				born_q <= head.born;
				died_q <= head.died;
			end else begin
				if (mem_we) begin
					born_q <= born_next;
				end
				if (rd_en) begin
					died_q <= died_next;
				end
			end
			if (mem_we) begin
				seg_cnt_q <= seg_cnt_q + 1'b1;
			end
			if (load_err) begin
				ovf_q <= 1'b1;
			end
			if (load_res || load_err) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign results.valid          = out_valid_q;
	assign results.column         = out_col_q;
	assign results.start_row      = out_start_q;
	assign results.end_row        = signed'(out_end_q);
	assign results.segment_number = out_seg_q;
	assign results.overflow       = out_ovf_q;
	assign results.last           = out_last_q;

endmodule

@@ rtl/core/vertical_run_segment_tracker_core.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Handshake      Payload
// items     in   valid/ready    byte_index, above_bits, filtered_bits, next_bits, row
// results   out  valid/ready    column, start_row, end_row, segment_number, overflow, last
// config    in   wr_en only     wr_index, wr_data (row_bytes, segment_limit, end_lag)
//
// Steps: the back end takes a byte off the queue, then does one column store write per
// birth and, per death, a store read and then a result load, which waits while the
// output register is still held; the single-port column store sets this order.
// Reset: arst_n clears control, counters and the overflow flag; the column store
// is not cleared (entries must be read only after a birth wrote them; the block does not enforce this).
// Stalls: a 4-deep queue parts front and back; results sit in an output register.

module vertical_run_segment_tracker_core (
	input  logic                            clk,
	input  logic                            arst_n,
	vrst_in_if.sink                         items,
	vrst_out_if.source                      results,
	input  logic                            wr_en,
	input  logic [vrst_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [vrst_pkg::CFG_DATA_W-1:0] wr_data
);
	import vrst_pkg::*;

	logic [RB_W-1:0]  row_bytes_q;
	logic [SEG_W-1:0] segment_limit_q;
	logic [LAG_W-1:0] end_lag_q;

	logic  push;
	logic  pop;
	logic  full;
	logic  empty;
	work_t push_data;
	work_t head;

	// Configuration registers; writes must arrive only while the block is idle, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q     <= ROW_BYTES_RST;
			segment_limit_q <= SEGMENT_LIMIT_RST;
			end_lag_q       <= END_LAG_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ROW_BYTES:     row_bytes_q     <= wr_data[RB_W-1:0];
				REG_SEGMENT_LIMIT: segment_limit_q <= wr_data[SEG_W-1:0];
				REG_END_LAG:       end_lag_q       <= wr_data[LAG_W-1:0];
				default:           ; // unmapped index, ignored
			endcase
		end
	end

	// Front: classify births and deaths, drop skipped or empty bytes,
	// precompute start and end rows.
	vrst_front u_front (
		.items     (items),
		.row_bytes (row_bytes_q),
		.end_lag   (end_lag_q),
		.full      (full),
		.push      (push),
		.push_data (push_data)
	);

	vrst_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.pop_data  (head),
		.empty     (empty)
	);

	// Back: births into the column store, then deaths out left to right.
	// After overflow, queued transactions are drained without effect.
	vrst_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.segment_limit (segment_limit_q),
		.empty         (empty),
		.head          (head),
		.pop           (pop),
		.results       (results)
	);

endmodule

@@ tb/tb_vertical_run_segment_tracker_core.sv @@
`timescale 1ns / 1ps

// Drives pixel-column bytes into the segment tracker and checks every closed-segment
// transaction against an in-bench tracker that keeps its own column store, segment
// counter, overflow flag and register copies, or against outcomes typed in the table.
module tb_vertical_run_segment_tracker_core;
	import vrst_pkg::*;

	// Wait after the last expected result before touching registers. A byte with
	// births only yields nothing but still costs back-end cycles. It covers four queued bytes
	// of up to eight births and eight deaths each, plus the front and the output register.
	localparam int SETTLE_CYCLES  = 150;
	// Cycles with no transaction on either channel before the run is declared hung.
	// The longest legal quiet stretch is the receiver hold-off below.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int IDLE_PCT       = 15;

	typedef struct packed {
		logic [BIDX_W-1:0] byte_index;
		logic [BITS_W-1:0] above_bits;
		logic [BITS_W-1:0] filtered_bits;
		logic [BITS_W-1:0] next_bits;
		logic [ROW_W-1:0]  row;
	} byte_item_t;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] start_row;
		logic [END_W-1:0] end_row;
		logic [SEG_W-1:0] segment_number;
		logic             overflow;
		logic             last;
	} closure_t;

	// One row of the directed table: a register write or a byte. n_typed < 0 means
	// the tracker below supplies the expected closures, else the row carries them.
	typedef struct {
		bit                    is_write;
		cfg_reg_t              reg_sel;
		logic [CFG_DATA_W-1:0] wdata;
		byte_item_t            item;
		int                    n_typed;
		closure_t              typed;
	} step_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	vrst_in_if  items_if ();
	vrst_out_if results_if ();

	vertical_run_segment_tracker_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.items    (items_if),
		.results  (results_if),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always #2 clk = ~clk;

	// Tracker state, mirrors the block
	logic [ROW_W-1:0]  col_start_mem [MAX_COLUMNS];
	logic [SEG_W-1:0]  col_seg_mem   [MAX_COLUMNS];
	bit                col_written   [MAX_COLUMNS];   // store entry holds a birth
	logic [SEG_W-1:0]  seg_count;
	bit                overflowed;
	logic [RB_W-1:0]   rb_cfg;
	logic [SEG_W-1:0]  limit_cfg;
	logic [LAG_W-1:0]  lag_cfg;

	closure_t fresh[$];     // closures of the byte just taken
	closure_t pending[$];   // closures still owed by the block
	step_t    script[$];

	int fail_count    = 0;
	int idle_cycles   = 0;
	bit calm          = 1'b0;   // no idling on either side
	bit stall_request = 1'b0;   // main asks for one long receiver hold-off
	bit stall_done    = 1'b0;   // receiver has served it

	// Births first, left to right; a birth at the limit trips overflow and ends the
	// byte. Then deaths, left to right, each reading the stored start and number.
	function automatic void predict_closures(byte_item_t it);
		logic [BITS_W-1:0] born;
		logic [BITS_W-1:0] died;
		logic [END_W-1:0]  end_v;
		closure_t          c;
		int                col;
		fresh.delete();
		if (overflowed || int'(it.byte_index) + 1 >= int'(rb_cfg)) begin
			return;
		end
		born = it.above_bits & ~it.filtered_bits;
		for (int j = 0; j < BITS_W; j++) begin
			if (born[BITS_W - 1 - j]) begin
				if (seg_count >= limit_cfg) begin
					overflowed = 1'b1;
					c = '0;
					c.overflow = 1'b1;
					c.last = 1'b1;
					fresh.push_back(c);
					return;
				end
				col = (int'(it.byte_index) * BITS_W + j) % MAX_COLUMNS;
				col_start_mem[col] = it.row - START_OFFSET;
				col_seg_mem[col] = seg_count;
				col_written[col] = 1'b1;
				seg_count = seg_count + 1'b1;
			end
		end
		died = ~it.filtered_bits & it.next_bits;
		end_v = END_W'({1'b0, it.row}) - END_W'(1) - END_W'(lag_cfg);
		for (int j = 0; j < BITS_W; j++) begin
			if (died[BITS_W - 1 - j]) begin
				col = (int'(it.byte_index) * BITS_W + j) % MAX_COLUMNS;
				c = '0;
				c.column = COL_W'(int'(it.byte_index) * BITS_W + j);
				c.start_row = col_start_mem[col];
				c.end_row = end_v;
				c.segment_number = col_seg_mem[col];
				fresh.push_back(c);
			end
		end
		if (fresh.size() > 0) begin
			c = fresh.pop_back();
			c.last = 1'b1;
			fresh.push_back(c);
		end
	endfunction

	// Random byte. Deaths are kept to columns whose store entry was written,
	// either earlier or by a birth in this same byte.
	function automatic byte_item_t random_byte();
		byte_item_t        it;
		logic [BITS_W-1:0] known;
		logic [BITS_W-1:0] died;
		int                rb;
		rb = int'(rb_cfg);
		if (rb >= 2 && $urandom_range(9) != 0) begin
			// in a full row, stay mostly near the left edge so columns get reused
			if (rb == 512 && $urandom_range(2) != 0) begin
				it.byte_index = BIDX_W'($urandom_range(15));
			end else begin
				it.byte_index = BIDX_W'($urandom_range(rb - 2));
			end
		end else begin
			it.byte_index = BIDX_W'($urandom_range(511));
		end
		it.above_bits = BITS_W'($urandom);
		it.filtered_bits = BITS_W'($urandom & $urandom);   // mostly black
		it.next_bits = BITS_W'($urandom);
		it.row = ROW_W'($urandom_range(65535, 16));
		known = it.above_bits & ~it.filtered_bits;
		for (int j = 0; j < BITS_W; j++) begin
			known[BITS_W - 1 - j] = known[BITS_W - 1 - j] |
				col_written[(int'(it.byte_index) * BITS_W + j) % MAX_COLUMNS];
		end
		died = ~it.filtered_bits & it.next_bits;
		it.next_bits = it.next_bits & ~(died & ~known);
		return it;
	endfunction

	// Register write, one cycle of wr_en, then wr_en low again so writes never abut
	task automatic apply_setting(cfg_reg_t sel, logic [CFG_DATA_W-1:0] v);
		wr_en <= 1'b1;
		wr_index <= sel;
		wr_data <= v;
		@(posedge clk);
		case (sel)
			REG_ROW_BYTES:     rb_cfg = RB_W'(v);
			REG_SEGMENT_LIMIT: limit_cfg = v;
			REG_END_LAG:       lag_cfg = LAG_W'(v);
			default: ;
		endcase
		wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Bring the block to idle: input dropped, all closures in, back end drained
	task automatic settle();
		items_if.valid <= 1'b0;
		while (pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Offer one byte with random gaps in front; on acceptance run the tracker
	task automatic offer_byte(byte_item_t it, bit from_tracker);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			items_if.valid <= 1'b0;
			@(posedge clk);
		end
		items_if.valid <= 1'b1;
		items_if.byte_index <= it.byte_index;
		items_if.above_bits <= it.above_bits;
		items_if.filtered_bits <= it.filtered_bits;
		items_if.next_bits <= it.next_bits;
		items_if.row <= it.row;
		do begin
			@(posedge clk);
		end while (items_if.ready !== 1'b1);
		predict_closures(it);
		if (from_tracker) begin
			foreach (fresh[k]) begin
				pending.push_back(fresh[k]);
			end
		end
	endtask

	task automatic add_write(cfg_reg_t sel, int v);
		step_t s;
		s.is_write = 1'b1;
		s.reg_sel = sel;
		s.wdata = CFG_DATA_W'(v);
		s.item = '0;
		s.n_typed = 0;
		s.typed = '0;
		script.push_back(s);
	endtask

	task automatic add_item(int bidx, int above, int filt, int nxt, int row);
		step_t s;
		s.is_write = 1'b0;
		s.reg_sel = REG_ROW_BYTES;
		s.wdata = '0;
		s.item = '{BIDX_W'(bidx), BITS_W'(above), BITS_W'(filt), BITS_W'(nxt), ROW_W'(row)};
		s.n_typed = -1;
		s.typed = '0;
		script.push_back(s);
	endtask

	// Byte with its outcome written out: nothing, or a single closure (last set)
	task automatic add_known(int bidx, int above, int filt, int nxt, int row, int count,
			int col, int start, int endv, int seg, bit ovf);
		step_t s;
		s.is_write = 1'b0;
		s.reg_sel = REG_ROW_BYTES;
		s.wdata = '0;
		s.item = '{BIDX_W'(bidx), BITS_W'(above), BITS_W'(filt), BITS_W'(nxt), ROW_W'(row)};
		s.n_typed = count;
		s.typed = '{COL_W'(col), ROW_W'(start), END_W'(endv), SEG_W'(seg), ovf, 1'b1};
		script.push_back(s);
	endtask

	task automatic run_script();
		step_t s;
		while (script.size() != 0) begin
			s = script.pop_front();
			if (s.is_write) begin
				settle();
				apply_setting(s.reg_sel, s.wdata);
			end else begin
				offer_byte(s.item, s.n_typed < 0);
				if (s.n_typed == 1) begin
					pending.push_back(s.typed);
				end
			end
		end
	endtask

	// Random bytes until `goal` of them were actually processed, or `cap` sent.
	// Skipped bytes and bytes after overflow go through but do not count.
	task automatic random_phase(int goal, int cap);
		byte_item_t it;
		int         counted;
		int         sent;
		counted = 0;
		sent = 0;
		while (counted < goal && sent < cap) begin
			it = random_byte();
			if (!overflowed && int'(it.byte_index) + 1 < int'(rb_cfg)) begin
				counted++;
			end
			offer_byte(it, 1'b1);
			sent++;
		end
	endtask

	task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
		end
	endtask

	// Closure checker: each accepted result against the oldest expectation
	always @(posedge clk) begin : closure_check
		closure_t got;
		closure_t want;
		if (arst_n === 1'b1 && results_if.valid === 1'b1 && results_if.ready === 1'b1) begin
			got.column = results_if.column;
			got.start_row = results_if.start_row;
			got.end_row = results_if.end_row;
			got.segment_number = results_if.segment_number;
			got.overflow = results_if.overflow;
			got.last = results_if.last;
			if (pending.size() == 0) begin
				fail_count++;
				$display("%0t: closure with nothing expected, expected none, actual column %0h",
					$time, got.column);
			end else begin
				want = pending.pop_front();
				report_field("column", 32'(want.column), 32'(got.column));
				report_field("start_row", 32'(want.start_row), 32'(got.start_row));
				report_field("end_row", 32'(want.end_row), 32'(got.end_row));
				report_field("segment_number", 32'(want.segment_number),
					32'(got.segment_number));
				report_field("overflow", 32'(want.overflow), 32'(got.overflow));
				report_field("last", 32'(want.last), 32'(got.last));
			end
		end
	end

	// Result receiver: random back-pressure, one long hold-off on request
	initial begin : receiver
		int held;
		held = 0;
		results_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (stall_request && !stall_done) begin
				results_if.ready <= 1'b0;
				held++;
				if (held >= HOLD_CYCLES) begin
					stall_done = 1'b1;
				end
			end else begin
				results_if.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Hang detector: quiet cycles on both channels
	always @(posedge clk) begin
		if ((items_if.valid === 1'b1 && items_if.ready === 1'b1) ||
				(results_if.valid === 1'b1 && results_if.ready === 1'b1)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin : main
		arst_n = 1'b0;
		items_if.valid = 1'b0;
		items_if.byte_index = '0;
		items_if.above_bits = '0;
		items_if.filtered_bits = '0;
		items_if.next_bits = '0;
		items_if.row = '0;
		wr_en = 1'b0;
		wr_index = REG_ROW_BYTES;
		wr_data = '0;
		rb_cfg = ROW_BYTES_RST;
		limit_cfg = SEGMENT_LIMIT_RST;
		lag_cfg = END_LAG_RST;
		seg_count = '0;
		overflowed = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Segment numbers count up from 0 after reset.
		// Limit of one: a single birth is allowed, column 0 born and closed at once.
		add_write(REG_SEGMENT_LIMIT, 1);
		add_known(0, 8'h80, 8'h7F, 8'h80, 16, 1, 0, 0, 15, 0, 1'b0);
		add_write(REG_SEGMENT_LIMIT, 16'hFFFF);
		// Lowest row with the largest lag: end row goes negative
		add_write(REG_END_LAG, 63);
		add_known(0, 8'h01, 8'hFE, 8'h01, 16, 1, 7, 0, -48, 1, 1'b0);
		// Last processed byte of a full row: eight births, then eight closures
		add_known(510, 8'hFF, 8'h00, 8'h00, 16'hFFFF, 0, 0, 0, 0, 0, 1'b0);
		add_item(510, 8'h00, 8'h00, 8'hFF, 16'hFFFF);
		// Final byte of the row is skipped
		add_known(511, 8'hFF, 8'h00, 8'hFF, 100, 0, 0, 0, 0, 0, 1'b0);
		add_write(REG_END_LAG, 0);
		// Interleaved births and deaths in one byte, births taken first
		add_item(5, 8'hAA, 8'h00, 8'h00, 16'h8000);
		add_item(5, 8'h55, 8'h00, 8'hAA, 16'h7FFF);
		add_item(5, 8'h00, 8'hAA, 8'h55, 16'h8001);
		// All white: nothing happens
		add_known(100, 8'hFF, 8'hFF, 8'hFF, 300, 0, 0, 0, 0, 0, 1'b0);
		// One byte per row: every byte skipped
		add_write(REG_ROW_BYTES, 1);
		add_known(0, 8'hFF, 8'h00, 8'hFF, 200, 0, 0, 0, 0, 0, 1'b0);
		add_write(REG_ROW_BYTES, 512);
		// Column reborn with a new number, then closed
		add_item(0, 8'h80, 8'h7F, 8'h00, 1000);
		add_item(0, 8'h00, 8'h7F, 8'h80, 1200);
		run_script();

		// Random part, reset-like settings; first half with no idling at all
		calm = 1'b1;
		random_phase(20, 200);
		calm = 1'b0;
		random_phase(15, 200);

		// Short rows, max lag; receiver holds off while bytes keep coming
		settle();
		apply_setting(REG_ROW_BYTES, CFG_DATA_W'(37));
		apply_setting(REG_SEGMENT_LIMIT, CFG_DATA_W'(50000));
		apply_setting(REG_END_LAG, CFG_DATA_W'(63));
		stall_request = 1'b1;
		random_phase(25, 200);

		// Two bytes per row: only byte 0 is live
		settle();
		apply_setting(REG_ROW_BYTES, CFG_DATA_W'(2));
		apply_setting(REG_END_LAG, CFG_DATA_W'(17));
		random_phase(15, 200);

		// Everything skipped
		settle();
		apply_setting(REG_ROW_BYTES, CFG_DATA_W'(1));
		random_phase(100, 10);

		settle();
		apply_setting(REG_ROW_BYTES, CFG_DATA_W'(300));
		apply_setting(REG_SEGMENT_LIMIT, 16'hFFFF);
		apply_setting(REG_END_LAG, CFG_DATA_W'(5));
		random_phase(20, 200);

		// Limit one above the count: first birth of the byte is kept, the second one
		// trips overflow, deaths of that byte are dropped. Afterwards all is ignored.
		settle();
		add_write(REG_SEGMENT_LIMIT, int'(seg_count) + 1);
		add_known(2, 8'hC0, 8'h3F, 8'h80, 500, 1, 0, 0, 0, 0, 1'b1);
		add_known(0, 8'h80, 8'h7F, 8'h80, 600, 0, 0, 0, 0, 0, 1'b0);
		run_script();
		random_phase(100, 8);

		// Drain and give stray closures time to show up
		items_if.valid <= 1'b0;
		while (pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
